// ===== hdl/sbe_pkg.sv =====
// Shared types, constants and the arctangent table for the signed bearing error block.
// No dependencies; every other file of the block imports or refers to this package.
`timescale 1ns / 1ps
`default_nettype none

package sbe_pkg;

	localparam int MIN_DIST_W        = 48;
	localparam int GUARD_BITS        = 8;
	localparam int MAX_STAGES        = 24;
	localparam int DEF_COORD_BITS    = 24;
	localparam int DEF_ANGLE_BITS    = 16;
	localparam int DEF_CORDIC_STAGES = 16;
	localparam int Z_W               = 32;

	// Control bits that travel with each item down the pipeline.
	typedef struct packed {
		logic valid;
		logic close;
	} sbe_ctl_t;

	// round(atan(2^-i) * 2^32 / (2*pi)), a full turn is 2^32.
	function automatic logic [Z_W-1:0] sbe_atan(input int idx);
		logic [Z_W-1:0] r;
		case (idx)
			0:       r = 32'h20000000;
			1:       r = 32'h12e4051e;
			2:       r = 32'h09fb385b;
			3:       r = 32'h051111d4;
			4:       r = 32'h028b0d43;
			5:       r = 32'h0145d7e1;
			6:       r = 32'h00a2f61e;
			7:       r = 32'h00517c55;
			8:       r = 32'h0028be53;
			9:       r = 32'h00145f2f;
			10:      r = 32'h000a2f98;
			11:      r = 32'h000517cc;
			12:      r = 32'h00028be6;
			13:      r = 32'h000145f3;
			14:      r = 32'h0000a2fa;
			15:      r = 32'h0000517d;
			16:      r = 32'h000028be;
			17:      r = 32'h0000145f;
			18:      r = 32'h00000a30;
			19:      r = 32'h00000518;
			20:      r = 32'h0000028c;
			21:      r = 32'h00000146;
			22:      r = 32'h000000a3;
			23:      r = 32'h00000051;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/sbe_if.sv =====
// Valid/ready channel interfaces for position items and turn result items.
// Depends on sbe_pkg for default widths.
`timescale 1ns / 1ps
`default_nettype none

interface sbe_pos_if #(
	parameter int COORD_BITS = sbe_pkg::DEF_COORD_BITS,
	parameter int ANGLE_BITS = sbe_pkg::DEF_ANGLE_BITS
);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] own_x;
	logic signed [COORD_BITS-1:0] own_y;
	logic        [ANGLE_BITS-1:0] heading;
	logic signed [COORD_BITS-1:0] target_x;
	logic signed [COORD_BITS-1:0] target_y;

	modport source (output valid, own_x, own_y, heading, target_x, target_y, input ready);
	modport sink (input valid, own_x, own_y, heading, target_x, target_y, output ready);
endinterface

interface sbe_turn_if #(
	parameter int ANGLE_BITS = sbe_pkg::DEF_ANGLE_BITS
);
	logic                         valid;
	logic                         ready;
	logic signed [ANGLE_BITS-1:0] turn_angle;
	logic                         too_close;

	modport source (output valid, turn_angle, too_close, input ready);
	modport sink (input valid, turn_angle, too_close, output ready);
endinterface

`default_nettype wire

// ===== hdl/signed_bearing_error_top.sv =====
// Top level of the signed bearing error block: threshold register, front end,
// chain of CORDIC cells and output stage. Depends on sbe_pkg, sbe_if and all sbe_ modules.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir   Handshake     Payload
// pos       in    valid/ready   own_x, own_y, heading, target_x, target_y
// turn      out   valid/ready   turn_angle, too_close
// cfg       in    cfg_we        cfg_wdata (min_dist_sq, 48 bits)
//
// An item is accepted every cycle when the output is taken. The pipeline holds
// three front-end stages, one per CORDIC cell, and one output stage.
// Each stage stalls only when it holds an item and the stage after it cannot take one,
// so bubbles close up while the output waits. Reset clears all valid bits
// and sets the threshold to zero.

module signed_bearing_error_top #(
	parameter int COORD_BITS    = sbe_pkg::DEF_COORD_BITS,
	parameter int ANGLE_BITS    = sbe_pkg::DEF_ANGLE_BITS,
	parameter int CORDIC_STAGES = sbe_pkg::DEF_CORDIC_STAGES
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	sbe_pos_if.sink                             pos,
	sbe_turn_if.source                          turn,
	input  wire logic                           cfg_we,
	input  wire logic [sbe_pkg::MIN_DIST_W-1:0] cfg_wdata
);
	import sbe_pkg::*;

	localparam int XY_W = COORD_BITS + GUARD_BITS + 3;

	logic [MIN_DIST_W-1:0]  min_dist_sq_q;
	sbe_ctl_t               ctl_c [CORDIC_STAGES+1];
	logic signed [XY_W-1:0] x_c   [CORDIC_STAGES+1];
	logic signed [XY_W-1:0] y_c   [CORDIC_STAGES+1];
	logic [Z_W-1:0]         z_c   [CORDIC_STAGES+1];
	logic [ANGLE_BITS-1:0]  hdg_c [CORDIC_STAGES+1];
	logic                   rdy_c [CORDIC_STAGES+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_dist_sq_q <= '0;
		end else if (cfg_we) begin
			min_dist_sq_q <= cfg_wdata;
		end
	end

	sbe_front #(
		.COORD_BITS (COORD_BITS),
		.ANGLE_BITS (ANGLE_BITS),
		.XY_W       (XY_W)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.pos         (pos),
		.min_dist_sq (min_dist_sq_q),
		.ctl_o       (ctl_c[0]),
		.x_o         (x_c[0]),
		.y_o         (y_c[0]),
		.z_o         (z_c[0]),
		.hdg_o       (hdg_c[0]),
		.rdy_i       (rdy_c[0])
	);

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
		sbe_cell #(
			.XY_W       (XY_W),
			.ANGLE_BITS (ANGLE_BITS),
			.STAGE      (i)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl_i  (ctl_c[i]),
			.x_i    (x_c[i]),
			.y_i    (y_c[i]),
			.z_i    (z_c[i]),
			.hdg_i  (hdg_c[i]),
			.rdy_o  (rdy_c[i]),
			.ctl_o  (ctl_c[i+1]),
			.x_o    (x_c[i+1]),
			.y_o    (y_c[i+1]),
			.z_o    (z_c[i+1]),
			.hdg_o  (hdg_c[i+1]),
			.rdy_i  (rdy_c[i+1])
		);
	end

	sbe_back #(
		.ANGLE_BITS (ANGLE_BITS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl_i  (ctl_c[CORDIC_STAGES]),
		.z_i    (z_c[CORDIC_STAGES]),
		.hdg_i  (hdg_c[CORDIC_STAGES]),
		.rdy_o  (rdy_c[CORDIC_STAGES]),
		.turn   (turn)
	);

	// The final x and y of the chain are not needed; only the angle is used.

	// With the output slot empty every stage can move, so input must be ready.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!turn.valid |-> pos.ready)
		else $error("input not ready while the output slot is empty");

	a_empty_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !turn.valid)
		else $error("result item present right after reset");

	a_cfg_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> min_dist_sq_q == $past(cfg_wdata))
		else $error("threshold register did not take the written value");

endmodule

`default_nettype wire

// ===== hdl/sbe_front.sv =====
// Front end: difference vector, squared distance check and CORDIC pre-rotation.
// Three pipeline stages. Depends on sbe_pkg and sbe_pos_if.
`timescale 1ns / 1ps
`default_nettype none

module sbe_front #(
	parameter int COORD_BITS = sbe_pkg::DEF_COORD_BITS,
	parameter int ANGLE_BITS = sbe_pkg::DEF_ANGLE_BITS,
	parameter int XY_W       = COORD_BITS + sbe_pkg::GUARD_BITS + 3
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	sbe_pos_if.sink                               pos,
	input  wire logic [sbe_pkg::MIN_DIST_W-1:0]   min_dist_sq,
	output sbe_pkg::sbe_ctl_t                     ctl_o,
	output logic signed [XY_W-1:0]                x_o,
	output logic signed [XY_W-1:0]                y_o,
	output logic [sbe_pkg::Z_W-1:0]               z_o,
	output logic [ANGLE_BITS-1:0]                 hdg_o,
	input  wire logic                             rdy_i
);
	import sbe_pkg::*;

	localparam int DW    = COORD_BITS + 1;
	localparam int SQ_W  = 2 * DW;
	localparam int DSQ_W = SQ_W + 1;
	localparam int CMP_W = (DSQ_W > MIN_DIST_W) ? DSQ_W : MIN_DIST_W;

	logic                    v_s1, v_s2, v_s3;
	logic                    en_s1, en_s2, en_s3;
	logic signed [DW-1:0]    dx_d, dy_d;
	logic signed [DW-1:0]    dx_s1, dy_s1;
	logic [ANGLE_BITS-1:0]   hdg_s1, hdg_s2, hdg_s3;
	logic [DW-1:0]           ax, ay;
	logic [SQ_W-1:0]         sx_s2, sy_s2;
	logic signed [XY_W-1:0]  xg, yg;
	logic signed [XY_W-1:0]  x_s2, y_s2, x_s3, y_s3;
	logic [Z_W-1:0]          z_s2, z_s3;
	logic [DSQ_W-1:0]        dsq;
	logic                    close_s3;

	assign en_s3     = !v_s3 || rdy_i;
	assign en_s2     = !v_s2 || en_s3;
	assign en_s1     = !v_s1 || en_s2;
	assign pos.ready = en_s1;

	assign dx_d = DW'(pos.target_x) - DW'(pos.own_x);
	assign dy_d = DW'(pos.target_y) - DW'(pos.own_y);

	assign ax = dx_s1[DW-1] ? (~dx_s1 + 1'b1) : dx_s1;
	assign ay = dy_s1[DW-1] ? (~dy_s1 + 1'b1) : dy_s1;
	assign xg = XY_W'(dx_s1) <<< GUARD_BITS;
	assign yg = XY_W'(dy_s1) <<< GUARD_BITS;

	assign dsq = DSQ_W'(sx_s2) + DSQ_W'(sy_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= pos.valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			dx_s1  <= dx_d;
			dy_s1  <= dy_d;
			hdg_s1 <= pos.heading;
		end
		if (en_s2) begin
			sx_s2  <= SQ_W'(ax) * SQ_W'(ax);
			sy_s2  <= SQ_W'(ay) * SQ_W'(ay);
			hdg_s2 <= hdg_s1;
			// A vector in the left half plane is turned by half a turn first.
			if (dx_s1[DW-1]) begin
				x_s2 <= -xg;
				y_s2 <= -yg;
				z_s2 <= {1'b1, {(Z_W-1){1'b0}}};
			end else begin
				x_s2 <= xg;
				y_s2 <= yg;
				z_s2 <= '0;
			end
		end
		if (en_s3) begin
			close_s3 <= CMP_W'(dsq) <= CMP_W'(min_dist_sq);
			x_s3     <= x_s2;
			y_s3     <= y_s2;
			z_s3     <= z_s2;
			hdg_s3   <= hdg_s2;
		end
	end

	assign ctl_o.valid = v_s3;
	assign ctl_o.close = close_s3;
	assign x_o         = x_s3;
	assign y_o         = y_s3;
	assign z_o         = z_s3;
	assign hdg_o       = hdg_s3;

endmodule

`default_nettype wire

// ===== hdl/sbe_cell.sv =====
// One CORDIC vectoring cell: a single micro-rotation followed by a register.
// Depends on sbe_pkg for the arctangent table and the control struct.
`timescale 1ns / 1ps
`default_nettype none

module sbe_cell #(
	parameter int XY_W       = sbe_pkg::DEF_COORD_BITS + sbe_pkg::GUARD_BITS + 3,
	parameter int ANGLE_BITS = sbe_pkg::DEF_ANGLE_BITS,
	parameter int STAGE      = 0
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire sbe_pkg::sbe_ctl_t            ctl_i,
	input  wire logic signed [XY_W-1:0]       x_i,
	input  wire logic signed [XY_W-1:0]       y_i,
	input  wire logic [sbe_pkg::Z_W-1:0]      z_i,
	input  wire logic [ANGLE_BITS-1:0]        hdg_i,
	output logic                              rdy_o,
	output sbe_pkg::sbe_ctl_t                 ctl_o,
	output logic signed [XY_W-1:0]            x_o,
	output logic signed [XY_W-1:0]            y_o,
	output logic [sbe_pkg::Z_W-1:0]           z_o,
	output logic [ANGLE_BITS-1:0]             hdg_o,
	input  wire logic                         rdy_i
);
	import sbe_pkg::*;

	localparam logic [Z_W-1:0] ATAN = sbe_atan(STAGE);

	logic                   v_q, close_q, en, y_pos;
	logic signed [XY_W-1:0] xs, ys, x_q, y_q;
	logic [Z_W-1:0]         z_q;
	logic [ANGLE_BITS-1:0]  hdg_q;

	assign en    = !v_q || rdy_i;
	assign rdy_o = en;
	assign xs    = x_i >>> STAGE;
	assign ys    = y_i >>> STAGE;
	assign y_pos = !y_i[XY_W-1] && (y_i != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= ctl_i.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			close_q <= ctl_i.close;
			hdg_q   <= hdg_i;
			if (y_pos) begin
				x_q <= x_i + ys;
				y_q <= y_i - xs;
				z_q <= z_i + ATAN;
			end else begin
				x_q <= x_i - ys;
				y_q <= y_i + xs;
				z_q <= z_i - ATAN;
			end
		end
	end

	assign ctl_o.valid = v_q;
	assign ctl_o.close = close_q;
	assign x_o         = x_q;
	assign y_o         = y_q;
	assign z_o         = z_q;
	assign hdg_o       = hdg_q;

endmodule

`default_nettype wire

// ===== hdl/sbe_back.sv =====
// Back end: rounds the bearing, subtracts the heading (zero angle when too close) and holds the result item.
// Depends on sbe_pkg and sbe_turn_if.
`timescale 1ns / 1ps
`default_nettype none

module sbe_back #(
	parameter int ANGLE_BITS = sbe_pkg::DEF_ANGLE_BITS
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire sbe_pkg::sbe_ctl_t         ctl_i,
	input  wire logic [sbe_pkg::Z_W-1:0]   z_i,
	input  wire logic [ANGLE_BITS-1:0]     hdg_i,
	output logic                           rdy_o,
	sbe_turn_if.source                     turn
);
	import sbe_pkg::*;

	localparam logic [Z_W-1:0] HALF_LSB = Z_W'(1) << (Z_W - 1 - ANGLE_BITS);

	logic                         v_q, close_q, en;
	logic [Z_W-1:0]               z_rnd;
	logic [ANGLE_BITS-1:0]        bearing;
	logic signed [ANGLE_BITS-1:0] angle_q;

	assign en      = !v_q || turn.ready;
	assign rdy_o   = en;
	assign z_rnd   = z_i + HALF_LSB;
	assign bearing = z_rnd[Z_W-1 -: ANGLE_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= ctl_i.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			close_q <= ctl_i.close;
			angle_q <= ctl_i.close ? '0 : (bearing - hdg_i);
		end
	end

	assign turn.valid      = v_q;
	assign turn.turn_angle = angle_q;
	assign turn.too_close  = close_q;

	a_close_zero: assert property (@(posedge clk) disable iff (!arst_n)
		turn.valid && turn.too_close |-> turn.turn_angle == '0)
		else $error("too_close result carries a nonzero angle");

endmodule

`default_nettype wire
